### rtl/i2r_pkg.sv
// i2r_pkg: shared types, microcode rom and symbol tables for the roman numeral converter
// no dependencies; imported by integer_to_roman_numeral and its test bench
package i2r_pkg;

    localparam int ValueW = 12;
    localparam int SymW   = 7;
    localparam int DigitW = 4;
    localparam int DecW   = 2;
    localparam int PosW   = 3;
    localparam int RemW   = 14;
    localparam int LeftW  = 10;

    localparam logic [ValueW-1:0] ValueMax = ValueW'(3999);

    // ascii codes of the seven symbols
    localparam logic [SymW-1:0] SymI = 7'h49;
    localparam logic [SymW-1:0] SymV = 7'h56;
    localparam logic [SymW-1:0] SymX = 7'h58;
    localparam logic [SymW-1:0] SymL = 7'h4C;
    localparam logic [SymW-1:0] SymC = 7'h43;
    localparam logic [SymW-1:0] SymD = 7'h44;
    localparam logic [SymW-1:0] SymM = 7'h4D;
    localparam logic [SymW-1:0] SymNone = 7'h00;

    // microcode addresses
    typedef logic [1:0] t_addr;
    localparam t_addr ADDR_FETCH = 2'd0;
    localparam t_addr ADDR_EMIT  = 2'd1;
    localparam t_addr ADDR_ERR   = 2'd2;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_BAD,
        COND_LAST
    } t_cond;

    typedef enum logic {
        NEXT_INC,
        NEXT_HOLD
    } t_next;

    typedef struct packed {
        logic  accept;
        logic  emit;
        logic  err;
        t_cond cond;
        t_next seq;
        t_addr target;
    } t_uword;

    // symbol selector within a decade
    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN,
        SEL_END
    } t_sel;

    function automatic t_uword ucode_rom(input t_addr addr);
        t_uword w;
        case (addr)
            ADDR_FETCH: w = '{accept: 1'b1, emit: 1'b0, err: 1'b0, cond: COND_BAD,
                              seq: NEXT_INC, target: ADDR_ERR};
            ADDR_EMIT:  w = '{accept: 1'b0, emit: 1'b1, err: 1'b0, cond: COND_LAST,
                              seq: NEXT_HOLD, target: ADDR_FETCH};
            ADDR_ERR:   w = '{accept: 1'b0, emit: 1'b1, err: 1'b1, cond: COND_ALWAYS,
                              seq: NEXT_HOLD, target: ADDR_FETCH};
            default:    w = '{accept: 1'b0, emit: 1'b0, err: 1'b0, cond: COND_ALWAYS,
                              seq: NEXT_HOLD, target: ADDR_FETCH};
        endcase
        return w;
    endfunction

    // k-th symbol of a decimal digit
    function automatic t_sel digit_pattern(input logic [DigitW-1:0] d,
                                           input logic [PosW-1:0] k);
        t_sel s;
        case (d)
            4'd1:    s = (k == 3'd0) ? SEL_ONE : SEL_END;
            4'd2:    s = (k < 3'd2) ? SEL_ONE : SEL_END;
            4'd3:    s = (k < 3'd3) ? SEL_ONE : SEL_END;
            4'd4:    s = (k == 3'd0) ? SEL_ONE : ((k == 3'd1) ? SEL_FIVE : SEL_END);
            4'd5:    s = (k == 3'd0) ? SEL_FIVE : SEL_END;
            4'd6:    s = (k == 3'd0) ? SEL_FIVE : ((k == 3'd1) ? SEL_ONE : SEL_END);
            4'd7:    s = (k == 3'd0) ? SEL_FIVE : ((k < 3'd3) ? SEL_ONE : SEL_END);
            4'd8:    s = (k == 3'd0) ? SEL_FIVE : ((k < 3'd4) ? SEL_ONE : SEL_END);
            4'd9:    s = (k == 3'd0) ? SEL_ONE : ((k == 3'd1) ? SEL_TEN : SEL_END);
            default: s = SEL_END;
        endcase
        return s;
    endfunction

    function automatic logic [SymW-1:0] decade_symbol(input logic [DecW-1:0] dec,
                                                      input t_sel sel);
        logic [SymW-1:0] c;
        case ({dec, sel})
            {2'd0, SEL_ONE}:  c = SymI;
            {2'd0, SEL_FIVE}: c = SymV;
            {2'd0, SEL_TEN}:  c = SymX;
            {2'd1, SEL_ONE}:  c = SymX;
            {2'd1, SEL_FIVE}: c = SymL;
            {2'd1, SEL_TEN}:  c = SymC;
            {2'd2, SEL_ONE}:  c = SymC;
            {2'd2, SEL_FIVE}: c = SymD;
            {2'd2, SEL_TEN}:  c = SymM;
            {2'd3, SEL_ONE}:  c = SymM;
            default:          c = SymNone;
        endcase
        return c;
    endfunction

    // m times the weight of the decade
    function automatic logic [RemW-1:0] digit_step(input logic [DecW-1:0] dec,
                                                   input logic [DigitW-1:0] m);
        logic [RemW-1:0] v;
        case (dec)
            2'd0:    v = RemW'(m);
            2'd1:    v = RemW'(m) * RemW'(10);
            2'd2:    v = RemW'(m) * RemW'(100);
            2'd3:    v = RemW'(m) * RemW'(1000);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/integer_to_roman_numeral.sv
// integer_to_roman_numeral: one number in, its roman numeral out, one character per item
// after a number is taken, the emit step skips its leading zero decades and then registers
//   the first character; a stalled output holds the emit step back
// a new number is taken only after the last character is registered; numerals run up to 15
//   characters, one character a cycle from the emit step, apart from decade changes and stalls
// out of range numbers give a single flagged item
// reset (i_rst_n low, synchronous) returns the step counter to fetch and empties the output
module integer_to_roman_numeral (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [i2r_pkg::ValueW-1:0]  i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [i2r_pkg::SymW-1:0]    o_symbol,
    output logic                        o_last,
    output logic                        o_out_of_range
);
    import i2r_pkg::*;

    // microcode step counter and the control word it fetches
    t_addr  r_addr, n_addr;
    t_uword uw;

    // digit datapath: current digit, its decade, symbol position, lower digits left
    logic [DigitW-1:0] r_digit, n_digit;
    logic [DecW-1:0]   r_dec, n_dec;
    logic [PosW-1:0]   r_k, n_k;
    logic [LeftW-1:0]  r_rem, n_rem;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [SymW-1:0]   r_symbol, n_symbol;
    logic              r_last, n_last;
    logic              r_oor, n_oor;

    logic              bad;
    logic              slot_free;
    t_sel              sel, sel_nx;
    logic              dig_end;
    logic              fire;
    logic              emitting;
    logic              advance;
    logic              out_last;
    logic              cond_true;

    // digit extraction: parallel compares against 1..9 times the decade weight
    logic [ValueW-1:0] ext_rem;
    logic [DecW-1:0]   ext_dec;
    logic [8:0]        ge;
    logic [DigitW-1:0] ext_digit;
    logic [RemW-1:0]   ext_left;

    always_comb begin
        uw        = ucode_rom(r_addr);
        bad       = (i_value == '0) || (i_value > ValueMax);
        slot_free = !r_out_valid || i_out_ready;
        sel       = digit_pattern(r_digit, r_k);
        sel_nx    = digit_pattern(r_digit, r_k + PosW'(1));
        dig_end   = (sel == SEL_END);

        // fetch takes thousands straight from the input; later steps peel the next decade
        ext_rem = uw.accept ? i_value : ValueW'(r_rem);
        ext_dec = uw.accept ? DecW'(3) : r_dec - DecW'(1);
        for (int k = 1; k <= 9; k++) begin
            ge[k-1] = RemW'(ext_rem) >= digit_step(ext_dec, DigitW'(k));
        end
        ext_digit = DigitW'($countones(ge));
        ext_left  = RemW'(ext_rem) - digit_step(ext_dec, ext_digit);

        // last character: pattern ends after this symbol and no lower digits remain
        out_last = uw.err || ((sel_nx == SEL_END) && (r_rem == '0));
        emitting = uw.emit && slot_free && (uw.err || !dig_end);
        advance  = uw.emit && !uw.err && dig_end;

        if (uw.accept) begin
            fire = i_in_valid;
        end else begin
            fire = emitting || advance;
        end

        case (uw.cond)
            COND_NEVER:  cond_true = 1'b0;
            COND_ALWAYS: cond_true = 1'b1;
            COND_BAD:    cond_true = bad;
            COND_LAST:   cond_true = emitting && out_last;
            default:     cond_true = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_addr = r_addr;
        if (fire) begin
            if (cond_true) begin
                n_addr = uw.target;
            end else if (uw.seq == NEXT_INC) begin
                n_addr = r_addr + t_addr'(1);
            end
        end
    end

    // datapath and output register
    always_comb begin
        n_digit     = r_digit;
        n_dec       = r_dec;
        n_k         = r_k;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_symbol    = r_symbol;
        n_last      = r_last;
        n_oor       = r_oor;

        if ((uw.accept && i_in_valid) || advance) begin
            n_digit = ext_digit;
            n_dec   = ext_dec;
            n_k     = '0;
            n_rem   = ext_left[LeftW-1:0];
        end else if (emitting) begin
            n_k = r_k + PosW'(1);
        end

        if (emitting) begin
            n_out_valid = 1'b1;
            n_symbol    = uw.err ? SymNone : decade_symbol(r_dec, sel);
            n_last      = out_last;
            n_oor       = uw.err;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= ADDR_FETCH;
            r_out_valid <= 1'b0;
        end else begin
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit  <= n_digit;
        r_dec    <= n_dec;
        r_k      <= n_k;
        r_rem    <= n_rem;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_oor    <= n_oor;
    end

    assign o_in_ready     = uw.accept;
    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_symbol;
    assign o_last         = r_last;
    assign o_out_of_range = r_oor;

    // an error item is always a single, closing, empty character
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_last && (o_symbol == SymNone)))
        else $error("error item not marked last or carries a symbol");

    // a rejected number goes straight to the error step
    a_bad_to_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && bad) |=> (r_addr == ADDR_ERR))
        else $error("out of range number did not reach the error step");

    // no new number is taken while a numeral is still being sent
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("input taken before the numeral finished");

    // symbol position never runs past the pattern length
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_addr == ADDR_EMIT) |-> (r_k <= PosW'(4)))
        else $error("symbol position out of bounds");

endmodule

### verif/integer_to_roman_numeral_test.sv
// integer_to_roman_numeral_test: self-checking bench for the roman numeral converter
// drives numbers over valid/ready, predicts every character and compares field by field
// depends on rtl/i2r_pkg.sv and rtl/integer_to_roman_numeral.sv
module integer_to_roman_numeral_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2r_pkg::*;

    localparam int ClkPeriodNs   = 8;
    localparam int ResetCycles   = 5;
    localparam int RandomItems   = 385;
    localparam int NumDirected   = 25;
    localparam int LongHold      = 300;   // receiver hold-off that backs the block up
    localparam int SettleCycles  = 24;    // beyond the worst per-number latency
    localparam int WatchdogLimit = 2000;  // cycles with no item moving on either side
    localparam int ReportLimit   = 10;

    // one character of a numeral as the block hands it out
    typedef struct packed {
        logic [SymW-1:0] symbol;
        logic            last;
        logic            out_of_range;
    } t_numeral_char;

    // number offered on the input side; typed rows carry their numeral as text,
    // and empty text stands for the out of range flag
    typedef struct {
        bit    typed;
        string text;
    } t_pending_offer;

    typedef struct {
        logic [ValueW-1:0] value;
        bit                typed;
        string             text;
    } t_directed_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [ValueW-1:0] i_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [SymW-1:0]   o_symbol;
    logic              o_last;
    logic              o_out_of_range;

    t_numeral_char  expected_chars[$];   // characters still owed by the block
    t_pending_offer offered_rows[$];     // how to predict each number put on the input
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    int             tx_calm = 0;
    int             rx_calm = 0;
    bit             rx_hold_req = 1'b0;

    // directed numbers: range limits, the longest numeral, every digit shape,
    // subtractive forms in each decade and a few bit patterns
    t_directed_row directed_rows [NumDirected] = '{
        '{12'd0,    1'b1, ""},
        '{12'd1,    1'b1, "I"},
        '{12'd3999, 1'b1, "MMMCMXCIX"},
        '{12'd4000, 1'b1, ""},
        '{12'd4095, 1'b1, ""},
        '{12'd3888, 1'b1, "MMMDCCCLXXXVIII"},
        '{12'd4,    1'b1, "IV"},
        '{12'd9,    1'b1, "IX"},
        '{12'd5,    1'b1, "V"},
        '{12'd1000, 1'b1, "M"},
        '{12'd3000, 1'b1, "MMM"},
        '{12'd2,    1'b0, ""},
        '{12'd3,    1'b0, ""},
        '{12'd6,    1'b0, ""},
        '{12'd7,    1'b0, ""},
        '{12'd8,    1'b0, ""},
        '{12'd40,   1'b0, ""},
        '{12'd90,   1'b0, ""},
        '{12'd400,  1'b0, ""},
        '{12'd900,  1'b0, ""},
        '{12'd1994, 1'b0, ""},
        '{12'd2048, 1'b0, ""},
        '{12'd1365, 1'b0, ""},
        '{12'd2730, 1'b0, ""},
        '{12'd444,  1'b0, ""}
    };

    integer_to_roman_numeral u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range)
    );

    always #(ClkPeriodNs / 2) i_clk = ~i_clk;

    // queue the numeral of one number, decade by decade from the thousands down
    function automatic void predict_numeral(input logic [ValueW-1:0] value);
        logic [SymW-1:0] text[$];
        logic [SymW-1:0] one_sym;
        logic [SymW-1:0] five_sym;
        logic [SymW-1:0] ten_sym;
        int unsigned     n;
        int unsigned     weight;
        int unsigned     d;
        n = value;
        if (n < 1 || n > ValueMax) begin
            // zero and anything past 3999 give a single flagged item
            expected_chars.push_back('{SymNone, 1'b1, 1'b1});
            return;
        end
        weight = 1000;
        while (weight > 0) begin
            case (weight)
                1000: begin
                    one_sym = SymM; five_sym = SymNone; ten_sym = SymNone;
                end
                100: begin
                    one_sym = SymC; five_sym = SymD; ten_sym = SymM;
                end
                10: begin
                    one_sym = SymX; five_sym = SymL; ten_sym = SymC;
                end
                default: begin
                    one_sym = SymI; five_sym = SymV; ten_sym = SymX;
                end
            endcase
            d = (n / weight) % 10;
            if (d == 4 || d == 9) begin
                // subtractive pair
                text.push_back(one_sym);
                text.push_back((d == 4) ? five_sym : ten_sym);
            end else begin
                if (d >= 5)
                    text.push_back(five_sym);
                repeat (d % 5) text.push_back(one_sym);
            end
            weight = weight / 10;
        end
        foreach (text[i])
            expected_chars.push_back('{text[i], (i == text.size() - 1), 1'b0});
    endfunction

    // queue a numeral typed in the directed table
    function automatic void expect_typed(input string text);
        if (text.len() == 0) begin
            expected_chars.push_back('{SymNone, 1'b1, 1'b1});
        end else begin
            for (int i = 0; i < text.len(); i++)
                expected_chars.push_back('{SymW'(text[i]), (i == text.len() - 1), 1'b0});
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_numeral_char want,
                                          input t_numeral_char got);
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
            $display({"mismatch at %0t ns: %s; expected symbol %h last %b range %b, ",
                      "got symbol %h last %b range %b"},
                     $time, what, want.symbol, want.last, want.out_of_range,
                     got.symbol, got.last, got.out_of_range);
    endfunction

    // wait drawn per item; now and then a calm stretch with no waiting at all
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // mostly legal numbers, a share of long numerals and out of range values
    function automatic logic [ValueW-1:0] draw_value();
        case ($urandom_range(0, 9))
            0: begin
                if ($urandom_range(0, 1) == 1)
                    return ValueW'(0);
                return ValueW'($urandom_range(4000, 4095));
            end
            1: return ValueW'($urandom_range(0, 4095));
            2: return ValueW'(1000 * $urandom_range(0, 3) + 100 * $urandom_range(6, 8)
                              + 10 * $urandom_range(6, 8) + $urandom_range(6, 8));
            default: return ValueW'($urandom_range(1, 3999));
        endcase
    endfunction

    // put one number on the input and hold it until taken; valid stays high
    // straight into the next number when no gap is drawn
    task automatic offer_item(input logic [ValueW-1:0] value, input bit typed,
                              input string text);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_rows.push_back('{typed, text});
        i_in_valid <= 1'b1;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering until every owed character has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // checker: outputs are compared before the item taken at the same edge is
    // predicted, since its first character is registered only after it is taken
    always @(posedge i_clk) begin
        t_numeral_char  got;
        t_numeral_char  want;
        t_pending_offer row;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_symbol, o_last, o_out_of_range};
                if (expected_chars.size() == 0) begin
                    note_mismatch("character with nothing owed", '0, got);
                end else begin
                    want = expected_chars.pop_front();
                    if (got.symbol !== want.symbol || got.last !== want.last
                            || got.out_of_range !== want.out_of_range)
                        note_mismatch("wrong character", want, got);
                end
            end
            if (i_in_valid && o_in_ready) begin
                row = offered_rows.pop_front();
                if (row.typed)
                    expect_typed(row.text);
                else
                    predict_numeral(i_value);
            end
        end
    end

    // watchdog: a run where nothing moves for too long is a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("timeout: no item moved for %0d cycles", WatchdogLimit);
            $display("** integer_to_roman_numeral: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls per character, plus one long hold-off on request
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = LongHold;
            end else begin
                stall = draw_wait(rx_calm);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // sender and end of run
    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_value    <= '0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            offer_item(directed_rows[r].value, directed_rows[r].typed, directed_rows[r].text);
        drain_results();

        for (int k = 0; k < RandomItems; k++) begin
            // receiver backs off for a long while as numbers keep coming,
            // so the block fills up and drops its input ready
            if (k == 120)
                rx_hold_req = 1'b1;
            // later the sender itself goes quiet until the output side is empty
            if (k == 260)
                drain_results();
            offer_item(draw_value(), 1'b0, "");
        end

        drain_results();
        repeat (SettleCycles) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            mismatch_count++;
            $display("%0d characters never arrived", expected_chars.size());
        end
        if (mismatch_count == 0)
            $display("** integer_to_roman_numeral: PASSED **");
        else
            $display("** integer_to_roman_numeral: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/i2r_pkg.sv
rtl/integer_to_roman_numeral.sv
verif/integer_to_roman_numeral_test.sv
